// ===== rtl/pssp_pkg.sv =====
// Shared types, codes and constants for the segmented font stream parser.
// No dependencies; used by every module in rtl/.
package pssp_pkg;

    // Segment header bytes
    localparam logic [7:0] SEG_MARKER  = 8'h80;
    localparam logic [7:0] TYPE_ASCII  = 8'd1;
    localparam logic [7:0] TYPE_BINARY = 8'd2;
    localparam logic [7:0] TYPE_EOF    = 8'd3;

    // Positions within a segment header (length bytes follow at 2..5)
    localparam logic [2:0] HDR_MARKER   = 3'd0;
    localparam logic [2:0] HDR_TYPE     = 3'd1;
    localparam logic [2:0] HDR_LEN_LAST = 3'd5;

    // Expected segment positions
    localparam logic [1:0] SEG_HEADER  = 2'd0;
    localparam logic [1:0] SEG_DATA    = 2'd1;
    localparam logic [1:0] SEG_TRAILER = 2'd2;
    localparam logic [1:0] SEG_END     = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_MARKER = 2'd1;
    localparam logic [1:0] ST_WRONG_TYPE = 2'd2;
    localparam logic [1:0] ST_TRUNCATED  = 2'd3;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Command queue between parser and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Output bus widths
    localparam int TDATA_W = 112;
    localparam int TUSER_W = 3;

    // One queue entry: up to one payload byte followed by an optional summary
    typedef struct packed {
        logic        has_payload;
        logic        has_summary;
        logic [7:0]  pay_byte;
        logic [1:0]  pay_tag;
        logic [31:0] hdr_len;
        logic [31:0] dat_len;
        logic [31:0] trl_len;
        logic [1:0]  status;
    } cmd_t;

    // Queue state seen by the output stage
    typedef struct packed {
        logic valid;
        cmd_t head;
    } queue_head_t;

    function automatic logic [7:0] expected_type(input logic [1:0] seg);
        logic [7:0] t;
        begin
            case (seg)
                SEG_HEADER:  t = TYPE_ASCII;
                SEG_DATA:    t = TYPE_BINARY;
                SEG_TRAILER: t = TYPE_ASCII;
                SEG_END:     t = TYPE_EOF;
                default:     t = TYPE_EOF;
            endcase
            expected_type = t;
        end
    endfunction

endpackage

// ===== rtl/pssp_front.sv =====
// Parser front end: accepts raw bytes, tracks segment headers and lengths,
// and pushes payload/summary commands. Depends on pssp_pkg.
module pssp_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [7:0]         in_byte,
    input  logic               in_eof,
    output logic               in_ready,
    input  logic               q_full,
    output logic               push,
    output pssp_pkg::cmd_t     push_cmd
);

    localparam logic [2:0] HDR_MARKER_C = pssp_pkg::HDR_MARKER;

    logic [2:0]  hdr_idx_reg, hdr_idx_next;
    logic        in_pay_reg, in_pay_next;
    logic [1:0]  seg_reg, seg_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] hdr_len_reg, hdr_len_next;
    logic [31:0] dat_len_reg, dat_len_next;
    logic [31:0] trl_len_reg, trl_len_next;
    logic [1:0]  status_reg, status_next;
    logic        fin_reg, fin_next;

    logic        accept;
    logic        pay_emit;
    logic [1:0]  lane;
    logic [31:0] acc_or;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign lane     = 2'(hdr_idx_reg - 3'd2);
    assign acc_or   = acc_reg | ({24'd0, in_byte} << {lane, 3'b000});

    always_comb
    begin
        hdr_idx_next = hdr_idx_reg;
        in_pay_next  = in_pay_reg;
        seg_next     = seg_reg;
        acc_next     = acc_reg;
        remain_next  = remain_reg;
        hdr_len_next = hdr_len_reg;
        dat_len_next = dat_len_reg;
        trl_len_next = trl_len_reg;
        status_next  = status_reg;
        fin_next     = fin_reg;
        pay_emit     = 1'b0;

        if (accept && !fin_reg)
        begin
            if (in_pay_reg)
            begin
                pay_emit    = 1'b1;
                remain_next = remain_reg - 32'd1;
                if (remain_reg == 32'd1)
                begin
                    in_pay_next  = 1'b0;
                    hdr_idx_next = HDR_MARKER_C;
                    seg_next     = seg_reg + 2'd1;
                end
            end
            else if (hdr_idx_reg == pssp_pkg::HDR_MARKER)
            begin
                if (in_byte != pssp_pkg::SEG_MARKER)
                begin
                    status_next = pssp_pkg::ST_BAD_MARKER;
                    fin_next    = 1'b1;
                end
                else
                begin
                    hdr_idx_next = pssp_pkg::HDR_TYPE;
                end
            end
            else if (hdr_idx_reg == pssp_pkg::HDR_TYPE)
            begin
                if (in_byte != pssp_pkg::expected_type(seg_reg))
                begin
                    status_next = pssp_pkg::ST_WRONG_TYPE;
                    fin_next    = 1'b1;
                end
                else if (in_byte == pssp_pkg::TYPE_EOF)
                begin
                    status_next = pssp_pkg::ST_OK;
                    fin_next    = 1'b1;
                end
                else
                begin
                    acc_next     = 32'd0;
                    hdr_idx_next = pssp_pkg::HDR_TYPE + 3'd1;
                end
            end
            else
            begin
                acc_next = acc_or;
                if (hdr_idx_reg != pssp_pkg::HDR_LEN_LAST)
                begin
                    hdr_idx_next = hdr_idx_reg + 3'd1;
                end
                else
                begin
                    if (seg_reg == pssp_pkg::SEG_HEADER)
                        hdr_len_next = acc_or;
                    else if (seg_reg == pssp_pkg::SEG_DATA)
                        dat_len_next = acc_or;
                    else
                        trl_len_next = acc_or;
                    hdr_idx_next = HDR_MARKER_C;
                    if (acc_or == 32'd0)
                    begin
                        seg_next = seg_reg + 2'd1;
                    end
                    else
                    begin
                        in_pay_next = 1'b1;
                        remain_next = acc_or;
                    end
                end
            end
        end

        // Summary snapshot is taken from the post-byte values
        push_cmd.has_payload = pay_emit;
        push_cmd.has_summary = in_eof;
        push_cmd.pay_byte    = in_byte;
        push_cmd.pay_tag     = seg_reg;
        push_cmd.hdr_len     = hdr_len_next;
        push_cmd.dat_len     = dat_len_next;
        push_cmd.trl_len     = trl_len_next;
        push_cmd.status      = fin_next ? status_next : pssp_pkg::ST_TRUNCATED;
        push                 = accept && (pay_emit || in_eof);

        // End of file: back to reset values for the next file
        if (accept && in_eof)
        begin
            hdr_idx_next = HDR_MARKER_C;
            in_pay_next  = 1'b0;
            seg_next     = pssp_pkg::SEG_HEADER;
            acc_next     = 32'd0;
            remain_next  = 32'd0;
            hdr_len_next = 32'd0;
            dat_len_next = 32'd0;
            trl_len_next = 32'd0;
            status_next  = pssp_pkg::ST_OK;
            fin_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_idx_reg <= HDR_MARKER_C;
            in_pay_reg  <= 1'b0;
            seg_reg     <= pssp_pkg::SEG_HEADER;
            acc_reg     <= 32'd0;
            remain_reg  <= 32'd0;
            hdr_len_reg <= 32'd0;
            dat_len_reg <= 32'd0;
            trl_len_reg <= 32'd0;
            status_reg  <= pssp_pkg::ST_OK;
            fin_reg     <= 1'b0;
        end
        else
        begin
            hdr_idx_reg <= hdr_idx_next;
            in_pay_reg  <= in_pay_next;
            seg_reg     <= seg_next;
            acc_reg     <= acc_next;
            remain_reg  <= remain_next;
            hdr_len_reg <= hdr_len_next;
            dat_len_reg <= dat_len_next;
            trl_len_reg <= trl_len_next;
            status_reg  <= status_next;
            fin_reg     <= fin_next;
        end
    end

endmodule

// ===== rtl/pssp_queue.sv =====
// Short command queue between parser front end and output stage.
// Depends on pssp_pkg (cmd_t, queue depth).
module pssp_queue
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  pssp_pkg::cmd_t            push_cmd,
    input  logic                      pop,
    output logic                      full,
    output pssp_pkg::queue_head_t     head
);

    localparam logic [pssp_pkg::QUEUE_AW:0] DEPTH_C =
        (pssp_pkg::QUEUE_AW + 1)'(pssp_pkg::QUEUE_DEPTH);
    localparam logic [pssp_pkg::QUEUE_AW-1:0] PTR_ONE_C =
        (pssp_pkg::QUEUE_AW)'(1);
    localparam logic [pssp_pkg::QUEUE_AW:0] CNT_ONE_C =
        (pssp_pkg::QUEUE_AW + 1)'(1);

    pssp_pkg::cmd_t                 mem_reg [pssp_pkg::QUEUE_DEPTH];
    logic [pssp_pkg::QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [pssp_pkg::QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [pssp_pkg::QUEUE_AW:0]    count_reg, count_next;

    assign full       = (count_reg == DEPTH_C);
    assign head.valid = (count_reg != '0);
    assign head.head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_ONE_C : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_ONE_C : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_ONE_C;
        else if (pop && !push)
            count_next = count_reg - CNT_ONE_C;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("queue count past depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> !full)
        else $error("push into full queue");

endmodule

// ===== rtl/pssp_back.sv =====
// Output stage: drains queued commands into the registered result stream,
// payload byte first, then the summary. Depends on pssp_pkg.
module pssp_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  pssp_pkg::queue_head_t            q,
    output logic                             pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pssp_pkg::TDATA_W-1:0]     m_tdata,
    output logic [pssp_pkg::TUSER_W-1:0]     m_tuser,
    output logic                             m_tlast
);

    logic        out_valid_reg, out_valid_next;
    logic        phase_reg, phase_next;      // payload half of a two-result entry sent
    logic [7:0]  byte_reg, byte_next;
    logic        kind_reg, kind_next;
    logic [1:0]  tag_reg, tag_next;
    logic [31:0] hdr_reg, hdr_next;
    logic [31:0] dat_reg, dat_next;
    logic [31:0] trl_reg, trl_next;
    logic [1:0]  status_reg, status_next;
    logic        load;
    logic        send_payload;

    assign load         = q.valid && (!out_valid_reg || m_tready);
    assign send_payload = q.head.has_payload && !phase_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        phase_next     = phase_reg;
        byte_next      = byte_reg;
        kind_next      = kind_reg;
        tag_next       = tag_reg;
        hdr_next       = hdr_reg;
        dat_next       = dat_reg;
        trl_next       = trl_reg;
        status_next    = status_reg;
        pop            = 1'b0;

        if (load)
        begin
            out_valid_next = 1'b1;
            if (send_payload)
            begin
                byte_next   = q.head.pay_byte;
                kind_next   = pssp_pkg::KIND_PAYLOAD;
                tag_next    = q.head.pay_tag;
                hdr_next    = 32'd0;
                dat_next    = 32'd0;
                trl_next    = 32'd0;
                status_next = pssp_pkg::ST_OK;
                if (q.head.has_summary)
                    phase_next = 1'b1;
                else
                    pop = 1'b1;
            end
            else
            begin
                byte_next   = 8'd0;
                kind_next   = pssp_pkg::KIND_SUMMARY;
                tag_next    = 2'd0;
                hdr_next    = q.head.hdr_len;
                dat_next    = q.head.dat_len;
                trl_next    = q.head.trl_len;
                status_next = q.head.status;
                phase_next  = 1'b0;
                pop         = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        kind_reg   <= kind_next;
        tag_reg    <= tag_next;
        hdr_reg    <= hdr_next;
        dat_reg    <= dat_next;
        trl_reg    <= trl_next;
        status_reg <= status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, status_reg, trl_reg, dat_reg, hdr_reg, byte_reg};
    assign m_tuser  = {tag_reg, kind_reg};
    assign m_tlast  = (kind_reg == pssp_pkg::KIND_SUMMARY);

    a_phase_entry: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (q.valid && q.head.has_payload && q.head.has_summary))
        else $error("split entry lost while summary pending");

    a_phase_summary: assert property (@(posedge clk) disable iff (!rst_n)
        (load && phase_reg) |=> (m_tvalid && kind_reg == pssp_pkg::KIND_SUMMARY))
        else $error("second half of split entry not a summary");

    a_no_early_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q.head.has_payload && q.head.has_summary) |-> phase_reg)
        else $error("entry popped before both results sent");

endmodule

// ===== rtl/pfb_segment_stream_parser.sv =====
// Top level of the segmented font stream parser.
// Depends on pssp_pkg, pssp_front, pssp_queue, pssp_back.
//
// Usage:
//   Slave side (s_t*) takes the font file one byte per transfer; s_tlast
//   flags the final byte of the file. Master side (m_t*) returns results:
//   payload bytes tagged by section (clear header, binary data, trailer),
//   and on the final byte a summary with the three declared section
//   lengths and a status (ok, bad marker, wrong type, truncated). The
//   summary has m_tlast set and follows the payload byte of the same input.
//   Segment header bytes and bytes after an error or the end marker give
//   no result, except the summary when such a byte is the final byte.
// Result path: a byte accepted while the queue is empty is written into
//   the command queue, then loaded into the output register on m_t*.
// Throughput: one byte per cycle while the command queue is not full; the
//   front parser decides each byte combinationally (counter update and
//   compares). A final byte with payload fills the output register twice.
// Reset: the parser returns to the first segment header, the queue and
//   output register empty. Parser state also returns to reset after every
//   final byte, ready for the next file.
// Stall: when m_tready is low the output register holds its transfer; the
//   four-entry command queue keeps taking bytes until full, then s_tready
//   drops.
module pfb_segment_stream_parser
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] in_byte
    input  logic                             s_tlast,   // end_of_file
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] out_byte, [39:8] header_length, [71:40] data_length,
    // [103:72] trailer_length, [105:104] parse_status, [111:106] zero
    output logic [pssp_pkg::TDATA_W-1:0]     m_tdata,
    // [0] result_kind, [2:1] section_tag
    output logic [pssp_pkg::TUSER_W-1:0]     m_tuser,
    output logic                             m_tlast    // last_result
);

    logic                   q_full;
    logic                   push;
    pssp_pkg::cmd_t         push_cmd;
    logic                   pop;
    pssp_pkg::queue_head_t  q_head;

    pssp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_eof   (s_tlast),
        .in_ready (s_tready),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    pssp_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .head     (q_head)
    );

    pssp_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q        (q_head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
